/* design/bbc_pkg.sv */
// Shared types, character codes and decode functions for the bracket balance checker.
package bbc_pkg;

  // Bracket type as stored on the stack.
  typedef enum logic [1:0] {
    BR_ROUND  = 2'd0,
    BR_SQUARE = 2'd1,
    BR_CURLY  = 2'd2,
    BR_NONE   = 2'd3
  } bracket_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  // Result handed from the engine to the output register.
  typedef struct packed {
    logic    done;
    status_t status;
  } bbc_result_t;

  // Character codes.
  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

  // Type of an opening bracket, or BR_NONE.
  function automatic bracket_t open_type(input logic [7:0] c);
    bracket_t t;
    case (c)
      CH_OPEN_ROUND:  t = BR_ROUND;
      CH_OPEN_SQUARE: t = BR_SQUARE;
      CH_OPEN_CURLY:  t = BR_CURLY;
      default:        t = BR_NONE;
    endcase
    return t;
  endfunction

  // Type of a closing bracket, or BR_NONE.
  function automatic bracket_t close_type(input logic [7:0] c);
    bracket_t t;
    case (c)
      CH_CLOSE_ROUND:  t = BR_ROUND;
      CH_CLOSE_SQUARE: t = BR_SQUARE;
      CH_CLOSE_CURLY:  t = BR_CURLY;
      default:         t = BR_NONE;
    endcase
    return t;
  endfunction

endpackage

/* design/bbc_stack_ram.sv */
// Stack storage: one write port and one registered read port.
module bbc_stack_ram
  import bbc_pkg::*;
#(
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  bracket_t          wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output bracket_t          rd_data
);

  bracket_t mem [(1 << ADDR_W)];
  bracket_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* design/bbc_engine.sv */
// Stack engine: top-of-stack register, entry count, error flags and memory prefetch.
module bbc_engine
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  char_byte,
  input  logic        end_of_string,
  output bbc_result_t result
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [CW-1:0] count_r, count_nxt, count_op;
  bracket_t      tos_r, tos_nxt;
  logic          mismatch_r, mismatch_nxt, mismatch_op;
  logic          overflow_r, overflow_nxt, overflow_op;
  logic          fwd_sel_r, fwd_sel_nxt;
  bracket_t      fwd_data_r;
  bracket_t      below;
  bracket_t      ot, ct;
  logic          wr_en;
  logic [CW-1:0] cnt_m1, rd_cnt;
  logic [AW-1:0] wr_addr, rd_addr;
  bracket_t      rd_data;

  // Memory holds every entry below the top one; the top lives in tos_r.
  bbc_stack_ram #(.ADDR_W(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (tos_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The entry under the top, forwarded when it was written last cycle.
  assign below   = fwd_sel_r ? fwd_data_r : rd_data;
  assign ot      = open_type(char_byte);
  assign ct      = close_type(char_byte);
  assign cnt_m1  = count_r - CW'(1);
  assign wr_addr = cnt_m1[AW-1:0];

  // Push, pop and flag updates for one character.
  always_comb begin
    count_op    = count_r;
    tos_nxt     = tos_r;
    mismatch_op = mismatch_r;
    overflow_op = overflow_r;
    wr_en       = 1'b0;
    if (step) begin
      if (ot != BR_NONE) begin
        if (count_r == CW'(STACK_DEPTH)) begin
          overflow_op = 1'b1;
        end else begin
          count_op = count_r + CW'(1);
          tos_nxt  = ot;
          wr_en    = (count_r != '0);
        end
      end else if (ct != BR_NONE) begin
        if (count_r == '0) begin
          mismatch_op = 1'b1;
        end else begin
          count_op = cnt_m1;
          tos_nxt  = below;
          if (tos_r != ct) begin
            mismatch_op = 1'b1;
          end
        end
      end
    end
  end

  // Status at the end of a string, then clear for the next one.
  always_comb begin
    result.done = step && end_of_string;
    if (overflow_op) begin
      result.status = ST_OVERFLOW;
    end else if (mismatch_op || (count_op != '0)) begin
      result.status = ST_INVALID;
    end else begin
      result.status = ST_VALID;
    end
    if (result.done) begin
      count_nxt    = '0;
      mismatch_nxt = 1'b0;
      overflow_nxt = 1'b0;
    end else begin
      count_nxt    = count_op;
      mismatch_nxt = mismatch_op;
      overflow_nxt = overflow_op;
    end
  end

  // Prefetch the entry that will sit under the next top.
  assign rd_cnt      = count_nxt - CW'(2);
  assign rd_addr     = rd_cnt[AW-1:0];
  assign fwd_sel_nxt = wr_en && (wr_addr == rd_addr);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      mismatch_r <= 1'b0;
      overflow_r <= 1'b0;
      fwd_sel_r  <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      mismatch_r <= mismatch_nxt;
      overflow_r <= overflow_nxt;
      fwd_sel_r  <= fwd_sel_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    tos_r      <= tos_nxt;
    fwd_data_r <= tos_r;
  end

endmodule

/* design/bracket_balance_checker.sv */
// Bracket balance checker top level: input handshake, stack engine and output register.
//
// Usage: one character arrives per request on the in_ channel (in_char_byte,
// in_end_of_string); a request is taken at a rising edge with in_valid high and
// in_stall low. Opening brackets push onto a stack in an internal memory,
// closing brackets pop it and compare. Other bytes pass without effect.
// The character that carries in_end_of_string yields one request on the out_
// channel: out_status is 0 for balanced, 1 for mismatch or unclosed brackets,
// 2 when the stack overflowed; all stack state then clears for the next string.
// Throughput: one character per cycle while in_stall is low. The top of the
// stack is held in a register and the entry beneath it is prefetched from the
// memory's registered read port, with write-to-read forwarding, so pushes and
// pops chain freely. A status reaches out_valid the cycle after its last character.
// When the receiver holds out_stall while a status waits, in_stall goes high
// until that status is taken; a status being taken frees the register at once.
// Reset (rst_n low, synchronous) empties the stack and clears out_valid; no
// memory clearing pass is needed.
module bracket_balance_checker
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status
);

  logic        in_take;
  bbc_result_t result;
  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r;

  // Hold input only while a finished status is waiting on a stalled receiver.
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  bbc_engine #(.STACK_DEPTH(STACK_DEPTH)) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_take),
    .char_byte     (in_char_byte),
    .end_of_string (in_end_of_string),
    .result        (result)
  );

  // Output register valid.
  always_comb begin
    if (result.done) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload loads only with a new status.
  always_ff @(posedge clk) begin
    if (result.done) begin
      out_status_r <= result.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

/* test/bbc_balance_check.sv */
`timescale 1ns / 100ps
// Checker that predicts the status of each string and compares it with the checker's results.
module bbc_balance_check
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_string,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_status,
  output int         error_count,
  output int         pending_count,
  output int         strings_seen,
  output int         overflow_strings
);

  // Predicted bracket stack and per-string flags.
  bracket_t open_stack [STACK_DEPTH];
  int       open_depth;
  bit       saw_mismatch;
  bit       saw_overflow;

  // Statuses predicted but not yet returned by the block.
  status_t  status_q [$];
  status_t  want;
  int       errors;
  int       strings_done;
  int       overflows;

  // Decode one byte into opening or closing bracket and its type.
  function automatic void decode_char(input logic [7:0] c, output bit opens,
                                      output bit closes, output bracket_t kind);
    opens  = 1'b0;
    closes = 1'b0;
    kind   = BR_NONE;
    case (c)
      CH_OPEN_ROUND: begin
        opens = 1'b1;
        kind  = BR_ROUND;
      end
      CH_OPEN_SQUARE: begin
        opens = 1'b1;
        kind  = BR_SQUARE;
      end
      CH_OPEN_CURLY: begin
        opens = 1'b1;
        kind  = BR_CURLY;
      end
      CH_CLOSE_ROUND: begin
        closes = 1'b1;
        kind   = BR_ROUND;
      end
      CH_CLOSE_SQUARE: begin
        closes = 1'b1;
        kind   = BR_SQUARE;
      end
      CH_CLOSE_CURLY: begin
        closes = 1'b1;
        kind   = BR_CURLY;
      end
      default: ;
    endcase
  endfunction

  // Apply one accepted character; the last one of a string yields a status.
  task automatic track_char(input logic [7:0] c, input logic last);
    bit       opens;
    bit       closes;
    bracket_t kind;
    status_t  st;
    decode_char(c, opens, closes, kind);
    if (opens) begin
      // A push onto a full stack is dropped and remembered as overflow.
      if (open_depth < STACK_DEPTH) begin
        open_stack[open_depth] = kind;
        open_depth++;
      end else begin
        saw_overflow = 1'b1;
      end
    end else if (closes) begin
      // Closing with nothing open, or with the wrong type, is a mismatch.
      if (open_depth == 0) begin
        saw_mismatch = 1'b1;
      end else begin
        open_depth--;
        if (open_stack[open_depth] != kind) saw_mismatch = 1'b1;
      end
    end
    if (last) begin
      // Overflow outranks an unbalanced string.
      if (saw_overflow) begin
        st = ST_OVERFLOW;
        overflows++;
      end else if (saw_mismatch || open_depth != 0) begin
        st = ST_INVALID;
      end else begin
        st = ST_VALID;
      end
      status_q.push_back(st);
      open_depth   = 0;
      saw_mismatch = 1'b0;
      saw_overflow = 1'b0;
    end
  endtask

  // Compare returned statuses first, then fold in the request taken at this edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      status_q.delete();
      open_depth   = 0;
      saw_mismatch = 1'b0;
      saw_overflow = 1'b0;
      errors       = 0;
      strings_done = 0;
      overflows    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: status %0d returned with no string pending", $time, out_status);
          end
        end else begin
          want = status_q.pop_front();
          strings_done++;
          if (out_status !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: status mismatch: expected %0d (%s), got %0d",
                       $time, want, want.name(), out_status);
            end
          end
        end
      end
      if (in_valid && !in_stall) track_char(in_char_byte, in_end_of_string);
    end
    error_count      <= errors;
    pending_count    <= status_q.size();
    strings_seen     <= strings_done;
    overflow_strings <= overflows;
  end

endmodule

/* test/bracket_balance_checker_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the bracket balance checker: clock, reset, character stimulus and verdict.
module bracket_balance_checker_tb;
  import bbc_pkg::*;

  localparam int STACK_DEPTH  = 128;
  localparam int RANDOM_CHARS = 240;
  localparam int QUIET_CHARS  = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_byte;
  logic       in_end_of_string;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_status;

  int error_count;
  int pending_count;
  int strings_seen;
  int overflow_strings;
  int cycle_count = 0;
  int chars_sent;
  bit gaps_on;
  bit stalls_on;

  // Characters of the string being built, sent in order.
  logic [7:0] text_q [$];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  bracket_balance_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_byte    (in_char_byte),
    .in_end_of_string(in_end_of_string),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status)
  );

  bbc_balance_check #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_byte    (in_char_byte),
    .in_end_of_string(in_end_of_string),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .error_count     (error_count),
    .pending_count   (pending_count),
    .strings_seen    (strings_seen),
    .overflow_strings(overflow_strings)
  );

  function automatic logic [7:0] opener(input bracket_t kind);
    case (kind)
      BR_ROUND:  return CH_OPEN_ROUND;
      BR_SQUARE: return CH_OPEN_SQUARE;
      default:   return CH_OPEN_CURLY;
    endcase
  endfunction

  function automatic logic [7:0] closer(input bracket_t kind);
    case (kind)
      BR_ROUND:  return CH_CLOSE_ROUND;
      BR_SQUARE: return CH_CLOSE_SQUARE;
      default:   return CH_CLOSE_CURLY;
    endcase
  endfunction

  function automatic bracket_t any_type();
    return bracket_t'($urandom_range(0, 2));
  endfunction

  // Any byte that is not one of the six bracket characters.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c inside {CH_OPEN_ROUND, CH_OPEN_SQUARE, CH_OPEN_CURLY,
                         CH_CLOSE_ROUND, CH_CLOSE_SQUARE, CH_CLOSE_CURLY});
    return c;
  endfunction

  // Any of the six bracket characters.
  function automatic logic [7:0] any_bracket();
    if ($urandom_range(0, 1) == 0) return opener(any_type());
    return closer(any_type());
  endfunction

  // Send one character; an optional idle burst comes first, then wait for acceptance.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_char_byte     <= c;
    in_end_of_string <= last;
    do @(posedge clk); while (in_stall);
    chars_sent++;
    @(negedge clk);
  endtask

  // Send the buffered characters, the last one marking the end of the string.
  task automatic send_string();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_string();
  endtask

  // Random nesting with plain characters mixed in, closed out at the end.
  task automatic build_nested(input int max_open);
    bracket_t open_q [$];
    bracket_t kind;
    int       steps;
    int       pick;
    text_q.delete();
    steps = $urandom_range(1, 20);
    repeat (steps) begin
      pick = $urandom_range(0, 3);
      if (pick < 2 && open_q.size() < max_open) begin
        kind = any_type();
        open_q.push_back(kind);
        text_q.push_back(opener(kind));
      end else if (pick == 2 && open_q.size() > 0) begin
        text_q.push_back(closer(open_q.pop_back()));
      end else begin
        text_q.push_back(plain_char());
      end
    end
    while (open_q.size() > 0) text_q.push_back(closer(open_q.pop_back()));
  endtask

  // Receiver back-pressure in random bursts, off near the end of the run.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    bracket_t open_q [$];
    int       random_end;
    int       kind;
    int       len;
    in_valid         = 1'b0;
    in_char_byte     = 8'h00;
    in_end_of_string = 1'b0;
    rst_n            = 1'b0;
    gaps_on          = 1'b1;
    stalls_on        = 1'b1;
    chars_sent       = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed strings: balanced, wrong type, close on empty, unclosed, plain bytes.
    send_text("()");
    send_text("[{}]");
    send_text("(]");
    send_text("{)");
    send_text(")");
    send_text("(");
    send_text("a(b]");
    text_q = '{8'h00};
    send_string();
    text_q = '{8'hFF};
    send_string();
    text_q = '{8'h00, CH_OPEN_SQUARE, 8'h00, CH_CLOSE_SQUARE};
    send_string();

    // Fill the stack exactly to its depth, then unwind: balanced.
    text_q.delete();
    open_q.delete();
    repeat (STACK_DEPTH) begin
      open_q.push_back(any_type());
      text_q.push_back(opener(open_q[$]));
    end
    while (open_q.size() > 0) text_q.push_back(closer(open_q.pop_back()));
    send_string();

    // One push past full, then a wrong close: overflow must win.
    text_q.delete();
    repeat (STACK_DEPTH + 1) text_q.push_back(CH_OPEN_ROUND);
    text_q.push_back(CH_CLOSE_CURLY);
    send_string();

    // Random strings, mostly well formed with a share of broken and junk ones.
    random_end = chars_sent + RANDOM_CHARS;
    while (chars_sent < random_end) begin
      if (chars_sent > random_end - QUIET_CHARS) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        build_nested($urandom_range(1, 12));
        // Corrupt some of them: swap in a random bracket or cut the tail.
        if (kind == 5) begin
          text_q[$urandom_range(0, text_q.size() - 1)] = any_bracket();
        end else if (kind == 6 && text_q.size() > 1) begin
          void'(text_q.pop_back());
        end
      end else begin
        text_q.delete();
        len = $urandom_range(1, 10);
        repeat (len) begin
          if (kind == 9 && $urandom_range(0, 2) != 0) begin
            text_q.push_back(any_bracket());
          end else begin
            text_q.push_back(8'($urandom_range(0, 255)));
          end
        end
      end
      send_string();
    end
    in_valid <= 1'b0;

    // Drain outstanding statuses, then allow the output stage to settle.
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters; %0d strings checked, %0d of them overflowed the %0d-deep stack.",
             chars_sent, strings_seen, overflow_strings, STACK_DEPTH);
    $display("Errors counted: %0d", error_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
